// File: rtl/core/iif_pkg.sv
// Package for the innermost interval filter.
// Holds the capacity, derived widths, the stored entry type and the order/containment tests.
// No dependencies.
package iif_pkg;

  localparam int CAPACITY = 64;
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] length;
    logic [31:0] toff;
    logic [31:0] tlen;
  } iif_entry_t;

  localparam int EW = $bits(iif_entry_t);

  // a strictly contains b; ends are taken at 33 bits
  function automatic logic iif_contains(iif_entry_t a, iif_entry_t b);
    logic [32:0] ae;
    logic [32:0] be;
    ae = {1'b0, a.start} + {1'b0, a.length};
    be = {1'b0, b.start} + {1'b0, b.length};
    return (a.start <= b.start) && (ae >= be) && ((a.start < b.start) || (ae > be));
  endfunction

  // x comes strictly before y in the emit order
  function automatic logic iif_before(iif_entry_t x, iif_entry_t y);
    return (x.start < y.start) || ((x.start == y.start) && (x.length > y.length));
  endfunction

endpackage

// File: rtl/core/iif_if.sv
// Valid/ready channel interfaces for the innermost interval filter.
// Depends on nothing; input and result channels carry their own payloads.
interface iif_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] interval_start;
  logic [31:0] interval_length;
  logic [31:0] tag_offset;
  logic [31:0] tag_length;
  logic        set_end;
  modport source (output valid, interval_start, interval_length, tag_offset, tag_length,
                  set_end, input ready);
  modport sink (input valid, interval_start, interval_length, tag_offset, tag_length,
                set_end, output ready);
endinterface

interface iif_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] kept_start;
  logic [31:0] kept_length;
  logic [31:0] kept_tag_offset;
  logic [31:0] kept_tag_length;
  logic        final_result;
  logic        overflowed;
  modport source (output valid, kept_start, kept_length, kept_tag_offset, kept_tag_length,
                  final_result, overflowed, input ready);
  modport sink (input valid, kept_start, kept_length, kept_tag_offset, kept_tag_length,
                final_result, overflowed, output ready);
endinterface

// File: rtl/core/innermost_interval_filter_core.sv
// Innermost interval filter: load one interval per cycle, then filter and emit in order.
// After set end, a containment pass compares each stored item against the whole store, then
// each survivor is picked by a selection scan over the store and then transferred.
// Throughput: one item per cycle while loading; the store's read port sets the end-of-set cost.
// Reset: synchronous rst clears count, overflow, survivor bits and output valid; store is not cleared.
module innermost_interval_filter_core
  import iif_pkg::*;
(
  input logic     clk,
  input logic     rst,
  iif_in_if.sink  in_ch,
  iif_out_if.source out_ch
);
  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_ARD   = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_SORT  = 3'd3;
  localparam logic [2:0] S_PUSH  = 3'd4;

  logic [2:0]          state;
  logic [CW-1:0]       entry_count;
  logic                overflow_flag;
  logic [CW-1:0]       remaining;
  logic [CAPACITY-1:0] live;
  logic [AW-1:0]       i_idx;
  logic [AW-1:0]       j_idx;
  logic                scan_on;
  logic                rd_v;
  logic [AW-1:0]       rd_idx;
  logic                drop;
  logic                have_best;
  logic [AW-1:0]       best_idx;
  iif_entry_t          best;
  iif_entry_t          a_data;
  iif_entry_t          b_data;
  iif_entry_t          wr_entry;
  logic                in_xfer;
  logic                full;
  logic                wr_en;
  logic [AW-1:0]       last_idx;
  logic                rd_last;
  logic                drop_now;
  logic                take;

  assign in_ch.ready = (state == S_LOAD);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign full        = (entry_count == CW'(CAPACITY));
  assign wr_en       = in_xfer && !full;
  assign wr_entry    = '{start: in_ch.interval_start, length: in_ch.interval_length,
                         toff: in_ch.tag_offset, tlen: in_ch.tag_length};
  assign last_idx    = AW'(entry_count - CW'(1));
  assign rd_last     = rd_v && (rd_idx == last_idx);
  assign drop_now    = drop || ((rd_idx != i_idx) && iif_contains(a_data, b_data));
  assign take        = live[rd_idx] && (!have_best || iif_before(b_data, best));

  iif_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_ram_a (
    .clk(clk), .we(wr_en), .waddr(entry_count[AW-1:0]), .wdata(wr_entry),
    .re(state == S_ARD), .raddr(i_idx), .rdata(a_data)
  );

  iif_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_ram_b (
    .clk(clk), .we(wr_en), .waddr(entry_count[AW-1:0]), .wdata(wr_entry),
    .re(scan_on), .raddr(j_idx), .rdata(b_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_LOAD;
      entry_count    <= '0;
      overflow_flag  <= 1'b0;
      remaining      <= '0;
      live           <= '0;
      i_idx          <= '0;
      j_idx          <= '0;
      scan_on        <= 1'b0;
      rd_v           <= 1'b0;
      drop           <= 1'b0;
      have_best      <= 1'b0;
      out_ch.valid   <= 1'b0;
    end else begin
      rd_v   <= scan_on;
      rd_idx <= j_idx;
      if (scan_on) begin
        if (j_idx == last_idx) begin
          scan_on <= 1'b0;
        end else begin
          j_idx <= j_idx + AW'(1);
        end
      end
      // the push state loads the next result itself
      if (out_ch.valid && out_ch.ready && (state != S_PUSH)) begin
        out_ch.valid <= 1'b0;
      end

      unique case (state)
        S_LOAD: begin
          if (in_xfer) begin
            if (full) begin
              overflow_flag <= 1'b1;
            end else begin
              entry_count <= entry_count + CW'(1);
            end
            if (in_ch.set_end) begin
              state     <= S_ARD;
              i_idx     <= '0;
              remaining <= '0;
            end
          end
        end
        S_ARD: begin
          state   <= S_CHECK;
          drop    <= 1'b0;
          scan_on <= 1'b1;
          j_idx   <= '0;
        end
        S_CHECK: begin
          if (rd_v) begin
            drop <= drop_now;
          end
          if (rd_last) begin
            live[i_idx] <= !drop_now;
            remaining   <= remaining + CW'(!drop_now);
            if (i_idx == last_idx) begin
              state     <= S_SORT;
              scan_on   <= 1'b1;
              j_idx     <= '0;
              have_best <= 1'b0;
            end else begin
              i_idx <= i_idx + AW'(1);
              state <= S_ARD;
            end
          end
        end
        S_SORT: begin
          // keep the earliest arrival on ties: replace only when strictly before
          if (rd_v && take) begin
            best      <= b_data;
            best_idx  <= rd_idx;
            have_best <= 1'b1;
          end
          if (rd_last) begin
            state <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (!out_ch.valid || out_ch.ready) begin
            out_ch.valid           <= 1'b1;
            out_ch.kept_start      <= best.start;
            out_ch.kept_length     <= best.length;
            out_ch.kept_tag_offset <= best.toff;
            out_ch.kept_tag_length <= best.tlen;
            out_ch.final_result    <= (remaining == CW'(1));
            out_ch.overflowed      <= overflow_flag;
            live[best_idx]         <= 1'b0;
            remaining              <= remaining - CW'(1);
            if (remaining == CW'(1)) begin
              state         <= S_LOAD;
              entry_count   <= '0;
              overflow_flag <= 1'b0;
            end else begin
              state     <= S_SORT;
              scan_on   <= 1'b1;
              j_idx     <= '0;
              have_best <= 1'b0;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CW'(CAPACITY)) else $error("entry count above capacity");
  a_push_best: assert property (@(posedge clk) disable iff (rst)
    state == S_PUSH |-> have_best && remaining != '0) else $error("push without candidate");
  a_check_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK || state == S_SORT) |-> entry_count != '0)
    else $error("filter pass on empty set");
  a_final_to_load: assert property (@(posedge clk) disable iff (rst)
    (state == S_PUSH && (!out_ch.valid || out_ch.ready) && remaining == CW'(1))
      |=> state == S_LOAD && out_ch.final_result) else $error("final result not marked");
endmodule

// File: rtl/core/iif_ram.sv
// Generic single-port-write, registered-read RAM.
// No dependencies; read data holds while the read enable is low.
module iif_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
